// ===== rtl/core/rtcp_pkg.sv =====
// Shared types and register indexes for the ray/triangle crossing parity block.
package rtcp_pkg;

  localparam int unsigned CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_POINT_X = 2'd0,
    CFG_POINT_Y = 2'd1,
    CFG_POINT_Z = 2'd2,
    CFG_UNUSED  = 2'd3
  } rtcp_cfg_idx_t;

  // Per-triangle verdict handed from the sequencer to the top level.
  typedef struct packed {
    logic done;
    logic hit;
  } rtcp_res_t;

endpackage

// ===== rtl/core/rtcp_mul.sv =====
// Shared signed multiplier with a registered product.
module rtcp_mul #(
  parameter int unsigned MW = 27
) (
  input  logic                   clk,
  input  logic signed [MW-1:0]   a,
  input  logic signed [MW-1:0]   b,
  output logic signed [2*MW-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

// ===== rtl/core/rtcp_seq.sv =====
// Sequencer and datapath that test one triangle using the shared multiplier.
module rtcp_seq #(
  parameter int unsigned CW = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [CW-1:0] px,
  input  logic signed [CW-1:0] py,
  input  logic signed [CW-1:0] pz,
  input  logic signed [CW-1:0] in_x [3],
  input  logic signed [CW-1:0] in_y [3],
  input  logic signed [CW-1:0] in_z [3],
  output rtcp_pkg::rtcp_res_t  res
);

  localparam int unsigned MW   = CW + 3;
  localparam int unsigned PW   = 2 * MW;
  localparam int unsigned CB   = 2 * CW + 3;
  localparam int unsigned LB   = CW + 2;
  localparam int unsigned ACCW = PW + LB;

  typedef enum logic [3:0] {
    S_IDLE, S_SORT, S_BOX, S_EA, S_EB, S_EC, S_CROSS, S_DOT, S_FIN
  } state_t;

  state_t                  state_r;
  logic [2:0]              cnt_r;
  logic signed [CW-1:0]    vx_r [3];
  logic signed [CW-1:0]    vy_r [3];
  logic signed [CW-1:0]    vz_r [3];
  logic signed [CW:0]      d1_r [3];
  logic signed [CW:0]      d2_r [3];
  logic signed [CW:0]      q_r  [3];
  logic signed [CB-1:0]    cr_r [3];
  logic signed [PW-1:0]    t_r;
  logic signed [ACCW-1:0]  acc_r;
  logic                    epar_r;
  logic                    cand_r;
  logic                    hit_r;
  logic                    done_r;

  logic signed [MW-1:0]    mul_a;
  logic signed [MW-1:0]    mul_b;
  logic signed [PW-1:0]    mul_p;

  logic [1:0]              si;
  logic [1:0]              sj;
  logic [1:0]              ea;
  logic [1:0]              eb;
  logic signed [CW:0]      e_px;
  logic signed [CW:0]      e_dy;
  logic signed [CW:0]      e_dx;
  logic signed [CW:0]      e_py;
  logic                    e_str;
  logic [2:0]              cap;
  logic signed [CW-1:0]    xmin;
  logic signed [CW-1:0]    xmax;
  logic                    inbox;
  logic signed [ACCW-1:0]  term;

  rtcp_mul #(.MW(MW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  function automatic logic signed [CW:0] sub1(logic signed [CW-1:0] a,
                                              logic signed [CW-1:0] b);
    sub1 = (CW+1)'(a) - (CW+1)'(b);
  endfunction

  // Sort pairs and edge pairs, both indexed by the step counter.
  always_comb begin
    unique case (cnt_r)
      3'd0:    begin si = 2'd0; sj = 2'd1; ea = 2'd0; eb = 2'd1; end
      3'd1:    begin si = 2'd0; sj = 2'd2; ea = 2'd1; eb = 2'd2; end
      default: begin si = 2'd1; sj = 2'd2; ea = 2'd0; eb = 2'd2; end
    endcase
  end

  assign e_px  = sub1(px, vx_r[ea]);
  assign e_dy  = sub1(vy_r[eb], vy_r[ea]);
  assign e_dx  = sub1(vx_r[eb], vx_r[ea]);
  assign e_py  = sub1(py, vy_r[ea]);
  assign e_str = (vy_r[ea] > py) != (vy_r[eb] > py);
  assign cap   = cnt_r - 3'd1;

  always_comb begin
    xmin = vx_r[0];
    xmax = vx_r[0];
    for (int j = 1; j < 3; j++) begin
      if (vx_r[j] < xmin) xmin = vx_r[j];
      if (vx_r[j] > xmax) xmax = vx_r[j];
    end
    inbox = (px >= xmin) && (px <= xmax) && (py >= vy_r[0]) && (py <= vy_r[2]);
  end

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_EA: begin mul_a = MW'(e_px); mul_b = MW'(e_dy); end
      S_EB: begin mul_a = MW'(e_dx); mul_b = MW'(e_py); end
      S_CROSS: begin
        case (cnt_r)
          3'd0:    begin mul_a = MW'(d1_r[1]); mul_b = MW'(d2_r[2]); end
          3'd1:    begin mul_a = MW'(d1_r[2]); mul_b = MW'(d2_r[1]); end
          3'd2:    begin mul_a = MW'(d1_r[2]); mul_b = MW'(d2_r[0]); end
          3'd3:    begin mul_a = MW'(d1_r[0]); mul_b = MW'(d2_r[2]); end
          3'd4:    begin mul_a = MW'(d1_r[0]); mul_b = MW'(d2_r[1]); end
          3'd5:    begin mul_a = MW'(d1_r[1]); mul_b = MW'(d2_r[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_DOT: begin
        if (cnt_r < 3'd6) begin
          // High part signed, low part unsigned.
          if (cnt_r[0]) begin
            mul_a = MW'({1'b0, cr_r[cnt_r[2:1]][LB-1:0]});
          end else begin
            mul_a = MW'($signed(cr_r[cnt_r[2:1]][CB-1:LB]));
          end
          mul_b = MW'(q_r[cnt_r[2:1]]);
        end
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign term = cap[0] ? ACCW'(mul_p) : (ACCW'(mul_p) <<< LB);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            for (int j = 0; j < 3; j++) begin
              vx_r[j] <= in_x[j];
              vy_r[j] <= in_y[j];
              vz_r[j] <= in_z[j];
            end
            cnt_r   <= '0;
            state_r <= S_SORT;
          end
        end
        S_SORT: begin
          // Swap only on strictly greater y.
          if (vy_r[si] > vy_r[sj]) begin
            vx_r[si] <= vx_r[sj]; vx_r[sj] <= vx_r[si];
            vy_r[si] <= vy_r[sj]; vy_r[sj] <= vy_r[si];
            vz_r[si] <= vz_r[sj]; vz_r[sj] <= vz_r[si];
          end
          if (cnt_r == 3'd2) begin
            state_r <= S_BOX;
          end else begin
            cnt_r <= cnt_r + 3'd1;
          end
        end
        S_BOX: begin
          d1_r[0] <= sub1(vx_r[1], vx_r[0]);
          d1_r[1] <= sub1(vy_r[1], vy_r[0]);
          d1_r[2] <= sub1(vz_r[1], vz_r[0]);
          d2_r[0] <= sub1(vx_r[2], vx_r[0]);
          d2_r[1] <= sub1(vy_r[2], vy_r[0]);
          d2_r[2] <= sub1(vz_r[2], vz_r[0]);
          q_r[0]  <= sub1(px, vx_r[0]);
          q_r[1]  <= sub1(py, vy_r[0]);
          q_r[2]  <= sub1(pz, vz_r[0]);
          cand_r  <= inbox;
          epar_r  <= 1'b0;
          cnt_r   <= '0;
          state_r <= inbox ? S_EA : S_FIN;
        end
        S_EA: begin
          state_r <= S_EB;
        end
        S_EB: begin
          t_r     <= mul_p;
          state_r <= S_EC;
        end
        S_EC: begin
          if (e_str && (t_r < mul_p)) epar_r <= ~epar_r;
          if (cnt_r == 3'd2) begin
            cnt_r <= '0;
            if (epar_r ^ (e_str && (t_r < mul_p))) begin
              state_r <= S_CROSS;
            end else begin
              cand_r  <= 1'b0;
              state_r <= S_FIN;
            end
          end else begin
            cnt_r   <= cnt_r + 3'd1;
            state_r <= S_EA;
          end
        end
        S_CROSS: begin
          if (cnt_r != 3'd0) begin
            if (cap[0]) begin
              cr_r[cap[2:1]] <= CB'(t_r - mul_p);
            end else begin
              t_r <= mul_p;
            end
          end
          if (cnt_r == 3'd6) begin
            cnt_r   <= '0;
            acc_r   <= '0;
            state_r <= S_DOT;
          end else begin
            cnt_r <= cnt_r + 3'd1;
          end
        end
        S_DOT: begin
          if (cnt_r != 3'd0) acc_r <= acc_r + term;
          if (cnt_r == 3'd6) begin
            state_r <= S_FIN;
          end else begin
            cnt_r <= cnt_r + 3'd1;
          end
        end
        S_FIN: begin
          // Hit when dot product is nonzero and shares the normal's z sign.
          hit_r   <= cand_r && (acc_r != '0) && (cr_r[2] != '0) &&
                     (acc_r[ACCW-1] == cr_r[2][CB-1]);
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign res.done = done_r;
  assign res.hit  = hit_r;

endmodule

// ===== rtl/core/ray_triangle_crossing_parity.sv =====
// Top level: configuration, handshakes, crossing parity and counter.
//
// Ray crossing parity of one query point against a streamed triangle mesh. Write
// the point through the cfg_ port (index 0/1/2 = x/y/z, signed fixed point with 16
// fraction bits), then stream triangles, one per input transaction, marking the
// final one with in_last_triangle. Each triangle is sorted by y, checked against
// its xy bounding box, put through a crossing test on each edge and a plane-side test
// for a ray toward negative z. After the last triangle one output transaction
// carries the parity (out_inside_res) and the saturating hit count. A triangle that
// misses the bounding box skips the edge and plane tests, and one that fails the
// edge test skips the plane test; all products are exact and go through one shared
// registered multiplier of COORD_BITS+3 bits per operand, which sets the pace. The
// input stalls while a triangle is in work or a result waits to be taken.
module ray_triangle_crossing_parity #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [COORD_BITS-1:0]       in_v0_x,
  input  logic signed [COORD_BITS-1:0]       in_v0_y,
  input  logic signed [COORD_BITS-1:0]       in_v0_z,
  input  logic signed [COORD_BITS-1:0]       in_v1_x,
  input  logic signed [COORD_BITS-1:0]       in_v1_y,
  input  logic signed [COORD_BITS-1:0]       in_v1_z,
  input  logic signed [COORD_BITS-1:0]       in_v2_x,
  input  logic signed [COORD_BITS-1:0]       in_v2_y,
  input  logic signed [COORD_BITS-1:0]       in_v2_z,
  input  logic                               in_last_triangle,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_inside_res,
  output logic [COUNT_BITS-1:0]              out_crossing_count,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rtcp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic signed [COORD_BITS-1:0]       cfg_data
);

  logic signed [COORD_BITS-1:0] point_x_r;
  logic signed [COORD_BITS-1:0] point_y_r;
  logic signed [COORD_BITS-1:0] point_z_r;
  logic                         busy_r;
  logic                         last_r;
  logic                         parity_r;
  logic [COUNT_BITS-1:0]        count_r;
  logic                         out_valid_r;
  logic                         out_inside_r;
  logic [COUNT_BITS-1:0]        out_count_r;
  logic                         parity_nxt;
  logic [COUNT_BITS-1:0]        count_nxt;
  logic                         in_acc;
  logic signed [COORD_BITS-1:0] vx [3];
  logic signed [COORD_BITS-1:0] vy [3];
  logic signed [COORD_BITS-1:0] vz [3];
  rtcp_pkg::rtcp_res_t          res;

  // Take a triangle only when idle and the result slot is free.
  assign in_ready  = !busy_r && !out_valid_r;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign vx[0] = in_v0_x; assign vy[0] = in_v0_y; assign vz[0] = in_v0_z;
  assign vx[1] = in_v1_x; assign vy[1] = in_v1_y; assign vz[1] = in_v1_z;
  assign vx[2] = in_v2_x; assign vy[2] = in_v2_y; assign vz[2] = in_v2_z;

  rtcp_seq #(.CW(COORD_BITS)) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .px    (point_x_r),
    .py    (point_y_r),
    .pz    (point_z_r),
    .in_x  (vx),
    .in_y  (vy),
    .in_z  (vz),
    .res   (res)
  );

  // Parity toggles on every hit; the count holds at its maximum.
  always_comb begin
    parity_nxt = parity_r;
    count_nxt  = count_r;
    if (res.hit) begin
      parity_nxt = ~parity_r;
      if (count_r != '1) count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_x_r   <= '0;
      point_y_r   <= '0;
      point_z_r   <= '0;
      busy_r      <= 1'b0;
      parity_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          rtcp_pkg::CFG_POINT_X: point_x_r <= cfg_data;
          rtcp_pkg::CFG_POINT_Y: point_y_r <= cfg_data;
          rtcp_pkg::CFG_POINT_Z: point_z_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (in_acc) begin
        busy_r <= 1'b1;
        last_r <= in_last_triangle;
      end
      if (res.done) begin
        busy_r <= 1'b0;
        if (last_r) begin
          // Deliver the result and restart the count.
          out_valid_r  <= 1'b1;
          out_inside_r <= parity_nxt;
          out_count_r  <= count_nxt;
          parity_r     <= 1'b0;
          count_r      <= '0;
        end else begin
          parity_r <= parity_nxt;
          count_r  <= count_nxt;
        end
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_inside_res     = out_inside_r;
  assign out_crossing_count = out_count_r;

`ifndef SYNTH
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> busy_r)
    else $error("triangle finished while block idle");

  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(res.done) && $past(last_r))
    else $error("result raised without a finished last triangle");

  a_parity_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_count_r != '1)) |-> (out_inside_r == out_count_r[0]))
    else $error("parity disagrees with unsaturated count");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !res.done |=> busy_r)
    else $error("busy dropped without a finished triangle");
`endif

endmodule

// ===== test/tb_top.sv =====
// Testbench for ray_triangle_crossing_parity: directed table plus random meshes.
`timescale 1ns / 100ps

module tb_top;

  typedef logic signed [23:0]  coord_t;
  typedef logic signed [127:0] wide_t;

  // One expected parity/count pair per mesh.
  typedef struct {
    bit          odd;
    logic [15:0] count;
  } verdict_t;

  // One row of the directed table; expectation typed in only where obvious.
  typedef struct {
    coord_t      v[9];
    bit          last;
    bit          has_exp;
    bit          e_inside;
    logic [15:0] e_count;
  } tri_row_t;

  localparam int     DRAIN_CYCLES = 40;
  localparam int     RANDOM_ITEMS = 1850;
  localparam coord_t C_MAX = 24'sh7FFFFF;
  localparam coord_t C_MIN = -24'sh800000;
  localparam coord_t ONE   = 24'sd65536;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  coord_t      in_v[9];
  logic        in_last_triangle = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_inside_res;
  logic [15:0] out_crossing_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [rtcp_pkg::CFG_IDX_BITS-1:0] cfg_index = rtcp_pkg::CFG_POINT_X;
  coord_t      cfg_data = '0;

  // Predictor state: query point, running parity and saturating count.
  coord_t      pt_x = '0, pt_y = '0, pt_z = '0;
  bit          parity_acc = 1'b0;
  logic [15:0] hits_acc = '0;
  verdict_t    pending_verdicts[$];

  int  errors = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  tri_row_t rows[$];

  initial for (int i = 0; i < 9; i++) in_v[i] = '0;

  always #5 clk = ~clk;

  ray_triangle_crossing_parity u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_v0_x            (in_v[0]),
    .in_v0_y            (in_v[1]),
    .in_v0_z            (in_v[2]),
    .in_v1_x            (in_v[3]),
    .in_v1_y            (in_v[4]),
    .in_v1_z            (in_v[5]),
    .in_v2_x            (in_v[6]),
    .in_v2_y            (in_v[7]),
    .in_v2_z            (in_v[8]),
    .in_last_triangle   (in_last_triangle),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_inside_res     (out_inside_res),
    .out_crossing_count (out_crossing_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Half-open edge test: the point's y straddles the edge and x lies left of it.
  function automatic bit edge_left(wide_t x, wide_t y, wide_t x0, wide_t y0,
                                   wide_t x1, wide_t y1);
    if ((y0 > y) == (y1 > y)) return 1'b0;
    return ((x - x0) * (y1 - y0)) < ((x1 - x0) * (y - y0));
  endfunction

  // Decide whether the downward ray from the query point hits this triangle.
  function automatic bit ray_hits(coord_t v[9]);
    wide_t vx[3], vy[3], vz[3], t;
    wide_t px, py, pz, d1x, d1y, d1z, d2x, d2y, d2z, cx, cy, cz, dot;
    wide_t bx0, bx1, by0, by1;
    int e;
    px = pt_x; py = pt_y; pz = pt_z;
    for (int j = 0; j < 3; j++) begin
      vx[j] = v[3*j]; vy[j] = v[3*j+1]; vz[j] = v[3*j+2];
      // Same compare-swap order as the sequencer: swap only on strictly greater y.
      for (int k = 0; k < j; k++) begin
        if (vy[k] > vy[j]) begin
          t = vx[k]; vx[k] = vx[j]; vx[j] = t;
          t = vy[k]; vy[k] = vy[j]; vy[j] = t;
          t = vz[k]; vz[k] = vz[j]; vz[j] = t;
        end
      end
    end
    bx0 = vx[0]; bx1 = vx[0]; by0 = vy[0]; by1 = vy[0];
    for (int j = 1; j < 3; j++) begin
      if (vx[j] < bx0) bx0 = vx[j];
      if (vx[j] > bx1) bx1 = vx[j];
      if (vy[j] < by0) by0 = vy[j];
      if (vy[j] > by1) by1 = vy[j];
    end
    if (px < bx0 || px > bx1 || py < by0 || py > by1) return 1'b0;
    e = edge_left(px, py, vx[0], vy[0], vx[1], vy[1])
      + edge_left(px, py, vx[1], vy[1], vx[2], vy[2])
      + edge_left(px, py, vx[0], vy[0], vx[2], vy[2]);
    if (e % 2 == 0) return 1'b0;
    d1x = vx[1] - vx[0]; d1y = vy[1] - vy[0]; d1z = vz[1] - vz[0];
    d2x = vx[2] - vx[0]; d2y = vy[2] - vy[0]; d2z = vz[2] - vz[0];
    cx = d1y * d2z - d1z * d2y;
    cy = d1z * d2x - d1x * d2z;
    cz = d1x * d2y - d1y * d2x;
    dot = cx * (px - vx[0]) + cy * (py - vy[0]) + cz * (pz - vz[0]);
    // Degenerate normal or point on the plane never counts.
    if (dot == 0 || cz == 0) return 1'b0;
    return (dot < 0) == (cz < 0);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Fold an accepted triangle into the running parity; close the mesh on last.
  task automatic predict_triangle(coord_t v[9], bit last, bit has_exp, bit e_in,
                                  logic [15:0] e_cnt);
    verdict_t vd;
    if (ray_hits(v)) begin
      parity_acc = ~parity_acc;
      if (hits_acc != 16'hFFFF) hits_acc++;
    end
    if (last) begin
      vd.odd    = has_exp ? e_in : parity_acc;
      vd.count  = has_exp ? e_cnt : hits_acc;
      pending_verdicts.push_back(vd);
      parity_acc = 1'b0;
      hits_acc   = '0;
    end
  endtask

  task automatic maybe_idle_in();
    if (!quiet && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Offer one triangle and hold it until accepted; valid stays up afterwards.
  task automatic send_triangle(coord_t v[9], bit last, bit has_exp = 0, bit e_in = 0,
                               logic [15:0] e_cnt = 0);
    maybe_idle_in();
    for (int i = 0; i < 9; i++) in_v[i] <= v[i];
    in_last_triangle <= last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_triangle(v, last, has_exp, e_in, e_cnt);
  endtask

  // Write one register, then hold valid low before the next write.
  task automatic write_reg(rtcp_pkg::rtcp_cfg_idx_t idx, coord_t val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rtcp_pkg::CFG_POINT_X: pt_x = val;
      rtcp_pkg::CFG_POINT_Y: pt_y = val;
      rtcp_pkg::CFG_POINT_Z: pt_z = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Wait out every pending verdict, then let the block settle back to idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_row(coord_t a[9], bit last, bit has_exp = 0, bit e_in = 0,
                         logic [15:0] e_cnt = 0);
    tri_row_t r;
    r.v = a; r.last = last; r.has_exp = has_exp; r.e_inside = e_in; r.e_count = e_cnt;
    rows.push_back(r);
  endtask

  // Random triangle: mostly scattered around the query point, some anywhere.
  task automatic random_triangle(output coord_t v[9]);
    int span, off;
    coord_t p[3];
    p[0] = pt_x; p[1] = pt_y; p[2] = pt_z;
    case ($urandom_range(2))
      0: span = 1 << 8;
      1: span = 1 << 16;
      default: span = 1 << 20;
    endcase
    if ($urandom_range(99) < 70) begin
      for (int i = 0; i < 9; i++) begin
        off  = int'($urandom_range(2 * span)) - span;
        v[i] = coord_t'(int'(p[i % 3]) + off);
      end
    end else begin
      for (int i = 0; i < 9; i++) v[i] = coord_t'($urandom);
    end
  endtask

  // Result side: random back-pressure plus one long hold-off on request.
  initial begin
    int hold_left;
    verdict_t vd;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("unexpected result, inside", out_inside_res, 0);
        end else begin
          vd = pending_verdicts.pop_front();
          if (out_inside_res !== vd.odd)
            report_mismatch("inside_res", out_inside_res, vd.odd);
          if (out_crossing_count !== vd.count)
            report_mismatch("crossing_count", out_crossing_count, vd.count);
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 10);
      end
    end
  end

  // Stimulus: directed table first, then a corner point, then point phases of random meshes.
  initial begin
    coord_t t[9];
    coord_t hit_tri[9], above_tri[9];
    int sent, next_phase, mesh_len, phase;
    bit hold_done;

    hit_tri   = '{-ONE, -ONE, -ONE, ONE, -ONE, -ONE, 0, ONE, -ONE};
    above_tri = '{-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE};

    // Point sits at the origin after reset, so these rows are read off directly.
    for (int i = 0; i < 9; i++) t[i] = C_MAX;
    add_row(t, 1, 1, 0, 0);
    for (int i = 0; i < 9; i++) t[i] = C_MIN;
    add_row(t, 1, 1, 0, 0);
    add_row(hit_tri, 1, 1, 1, 1);
    add_row(above_tri, 1, 1, 0, 0);
    add_row(hit_tri, 0);
    add_row(above_tri, 0);
    add_row(hit_tri, 0);
    add_row(hit_tri, 1, 1, 1, 3);
    // Collinear vertices: zero normal.
    add_row('{-ONE, 0, -ONE, 0, 0, -ONE, ONE, 0, -ONE}, 1);
    // Equal y on two vertices, given out of order.
    add_row('{0, ONE, -ONE, ONE, -ONE, -ONE, -ONE, -ONE, -ONE}, 1);
    // Point exactly on a vertex and on an edge.
    add_row('{0, 0, -ONE, ONE, ONE, -ONE, -ONE, ONE, -ONE}, 1);
    add_row('{-ONE, 0, -ONE, ONE, 0, -ONE, 0, ONE, -ONE}, 1);
    // Point lying in the triangle's plane.
    add_row('{-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0}, 1);
    // Mixed extremes spanning the whole range.
    add_row('{C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, 0, C_MAX, C_MIN}, 1);
    add_row('{C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, 0, C_MAX, C_MAX}, 1);
    add_row('{C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, 0}, 1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i])
      send_triangle(rows[i].v, rows[i].last, rows[i].has_exp, rows[i].e_inside,
                    rows[i].e_count);
    drain();

    // Extreme points: point at a corner of the range and a dud write, then triangles touching that corner.
    write_reg(rtcp_pkg::CFG_POINT_X, C_MAX);
    write_reg(rtcp_pkg::CFG_POINT_Y, C_MIN);
    write_reg(rtcp_pkg::CFG_POINT_Z, C_MAX);
    write_reg(rtcp_pkg::CFG_UNUSED, coord_t'($urandom));
    send_triangle('{C_MAX, C_MIN, C_MIN, C_MAX - ONE, C_MIN, C_MIN,
                    C_MAX, C_MIN + ONE, C_MIN}, 1);
    send_triangle('{C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN}, 1);
    drain();

    sent = 0;
    phase = 0;
    next_phase = 150;
    hold_done = 0;
    while (sent < RANDOM_ITEMS) begin
      mesh_len = $urandom_range(1, 8);
      for (int k = 0; k < mesh_len; k++) begin
        random_triangle(t);
        send_triangle(t, k == mesh_len - 1);
        sent++;
        quiet = (sent >= 500 && sent < 800);
        // Stall the result side once while triangles keep coming.
        if (!hold_done && sent >= 300) begin
          hold_done = 1;
          hold_req  = 1'b1;
        end
      end
      if (sent >= next_phase) begin
        next_phase += 150;
        phase++;
        drain();
        case (phase % 4)
          0: begin
            write_reg(rtcp_pkg::CFG_POINT_X, C_MIN);
            write_reg(rtcp_pkg::CFG_POINT_Y, C_MAX);
            write_reg(rtcp_pkg::CFG_POINT_Z, C_MIN);
          end
          1: begin
            write_reg(rtcp_pkg::CFG_POINT_X, '0);
            write_reg(rtcp_pkg::CFG_POINT_Y, '0);
            write_reg(rtcp_pkg::CFG_POINT_Z, '0);
          end
          default: begin
            write_reg(rtcp_pkg::CFG_POINT_X, coord_t'($urandom));
            write_reg(rtcp_pkg::CFG_POINT_Y, coord_t'($urandom));
            write_reg(rtcp_pkg::CFG_POINT_Z, coord_t'($urandom));
            if ($urandom_range(1)) write_reg(rtcp_pkg::CFG_UNUSED, coord_t'($urandom));
          end
        endcase
      end
    end

    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
